// File: rtl/mlt_pkg.sv
// mlt_pkg: shared constants, state encoding and command/status types
// for the multichannel linear tween block; no dependencies
package mlt_pkg;

  localparam int CHANNELS = 8;
  localparam int CHAN_W   = 3;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int CNT_W    = $clog2(DATA_W);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_CHECK,
    ST_MOD,
    ST_MUL,
    ST_QSTART,
    ST_QUO,
    ST_EMIT
  } mlt_state_e;

  typedef struct packed {
    logic              tick_latch;
    logic              start_wr;
    logic              load;
    logic              mod_start;
    logic              mod_take;
    logic              mul;
    logic              quo_start;
    logic              emit;
    logic [CHAN_W-1:0] idx;
  } mlt_cmd_t;

  typedef struct packed {
    logic cur_active;
    logic cur_last;
    logic need_mod;
    logic lerp;
    logic div_busy;
    logic out_free;
  } mlt_sts_t;

endpackage

// File: rtl/mlt_if.sv
// mlt_in_if / mlt_out_if: valid/ready channels for start/tick items and results
// depends on mlt_pkg
interface mlt_in_if;
  import mlt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [CHAN_W-1:0]        channel;
  logic [DATA_W-1:0]        time_req;
  logic signed [DATA_W-1:0] from_value;
  logic signed [DATA_W-1:0] to_value;
  logic [DATA_W-1:0]        duration;
  logic                     loop;

  modport source (output valid, kind, channel, time_req, from_value, to_value, duration, loop,
                  input ready);
  modport sink   (input valid, kind, channel, time_req, from_value, to_value, duration, loop,
                  output ready);
endinterface

interface mlt_out_if;
  import mlt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CHAN_W-1:0]        channel_out;
  logic signed [DATA_W-1:0] value;
  logic                     finished;
  logic                     last;

  modport source (output valid, channel_out, value, finished, last, input ready);
  modport sink   (input valid, channel_out, value, finished, last, output ready);
endinterface

// File: rtl/mlt_ctrl.sv
// mlt_ctrl: sequencer that walks the channels on a tick and steps the datapath
// depends on mlt_pkg
module mlt_ctrl
  import mlt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_kind_i,
  output logic     in_ready_o,
  input  mlt_sts_t sts_i,
  output mlt_cmd_t cmd_o
);

  mlt_state_e        st_q, st_d;
  logic [CHAN_W-1:0] idx_q, idx_d;
  logic              accept;
  logic              idx_end;

  assign in_ready_o = (st_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_end    = (int'(idx_q) == CHANNELS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
    end
  end

  // next state
  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept && in_kind_i == KIND_TICK) begin
          st_d  = ST_SCAN;
          idx_d = '0;
        end
      end
      ST_SCAN: begin
        if (sts_i.cur_active) begin
          st_d = ST_LOAD;
        end else if (idx_end) begin
          st_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CHAN_W'(1);
        end
      end
      ST_LOAD: st_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.need_mod) begin
          st_d = ST_MOD;
        end else if (sts_i.lerp) begin
          st_d = ST_MUL;
        end else begin
          st_d = ST_EMIT;
        end
      end
      ST_MOD: begin
        if (!sts_i.div_busy) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL:    st_d = ST_QSTART;
      ST_QSTART: st_d = ST_QUO;
      ST_QUO: begin
        if (!sts_i.div_busy) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.cur_last || idx_end) begin
            st_d = ST_IDLE;
          end else begin
            st_d  = ST_SCAN;
            idx_d = idx_q + CHAN_W'(1);
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    cmd_o.idx = idx_q;
    unique case (st_q)
      ST_IDLE: begin
        cmd_o.tick_latch = accept && in_kind_i == KIND_TICK;
        cmd_o.start_wr   = accept && in_kind_i == KIND_START;
      end
      ST_SCAN:   ;
      ST_LOAD:   cmd_o.load = 1'b1;
      ST_CHECK:  cmd_o.mod_start = sts_i.need_mod;
      ST_MOD:    cmd_o.mod_take = !sts_i.div_busy;
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_QSTART: cmd_o.quo_start = 1'b1;
      ST_QUO:    ;
      ST_EMIT:   cmd_o.emit = sts_i.out_free;
      default:   ;
    endcase
  end

`ifndef SYNTH
  a_idle_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> !sts_i.div_busy)
    else $error("divider busy while idle");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result emitted into a full output register");
  a_tick_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind_i == KIND_TICK) |=> (st_q == ST_SCAN && idx_q == '0))
    else $error("tick did not start a channel scan");
`endif

endmodule

// File: rtl/mlt_dp.sv
// mlt_dp: channel state, elapsed time, multiplier, shared serial divider
// and output register; depends on mlt_pkg
module mlt_dp
  import mlt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mlt_cmd_t                 cmd_i,
  output mlt_sts_t                 sts_o,
  input  logic [CHAN_W-1:0]        in_channel_i,
  input  logic [DATA_W-1:0]        in_time_i,
  input  logic signed [DATA_W-1:0] in_from_i,
  input  logic signed [DATA_W-1:0] in_to_i,
  input  logic [DATA_W-1:0]        in_dur_i,
  input  logic                     in_loop_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CHAN_W-1:0]        out_channel_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic                     out_finished_o,
  output logic                     out_last_o
);

  logic [DATA_W-1:0]        start_q [CHANNELS];
  logic signed [DATA_W-1:0] from_q  [CHANNELS];
  logic signed [DATA_W-1:0] to_q    [CHANNELS];
  logic [DATA_W-1:0]        dur_q   [CHANNELS];
  logic                     loop_q  [CHANNELS];
  logic [CHANNELS-1:0]      active_q;

  logic [DATA_W-1:0] time_q, elapsed_q, rem_q, dvd_q;
  logic [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;

  logic                     out_valid_q, out_fin_q, out_last_q;
  logic [CHAN_W-1:0]        out_ch_q;
  logic signed [DATA_W-1:0] out_val_q;

  logic [DATA_W-1:0]   from_cur, to_cur, dur_cur;
  logic [DATA_W:0]     diff, r33;
  logic [DATA_W-1:0]   mag, rem_step, lerp_val;
  logic                ge, ch_ok, fin;
  logic [CHANNELS-1:0] above;

  assign from_cur = from_q[cmd_i.idx];
  assign to_cur   = to_q[cmd_i.idx];
  assign dur_cur  = dur_q[cmd_i.idx];
  assign ch_ok    = (int'(in_channel_i) < CHANNELS);

  assign diff     = {to_cur[DATA_W-1], to_cur} - {from_cur[DATA_W-1], from_cur};
  assign mag      = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
  assign lerp_val = diff[DATA_W] ? from_cur - dvd_q : from_cur + dvd_q;

  // one restoring step: remainder stays below the divisor
  assign r33      = {rem_q, dvd_q[DATA_W-1]};
  assign ge       = (r33 >= {1'b0, dur_cur});
  assign rem_step = ge ? DATA_W'(r33 - {1'b0, dur_cur}) : r33[DATA_W-1:0];

  assign fin = !(elapsed_q < dur_cur);

  always_comb begin
    for (int j = 0; j < CHANNELS; j++) begin
      above[j] = active_q[j] && (j > int'(cmd_i.idx));
    end
  end

  assign sts_o.cur_active = active_q[cmd_i.idx];
  assign sts_o.cur_last   = ~|above;
  assign sts_o.need_mod   = loop_q[cmd_i.idx] && (dur_cur != '0) && !(elapsed_q < dur_cur);
  assign sts_o.lerp       = (elapsed_q < dur_cur);
  assign sts_o.div_busy   = busy_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start_wr && ch_ok) begin
        active_q[in_channel_i] <= 1'b1;
      end
      if (cmd_i.emit && fin) begin
        active_q[cmd_i.idx] <= 1'b0;
      end
      if (cmd_i.mod_start || cmd_i.quo_start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_wr && ch_ok) begin
      start_q[in_channel_i] <= in_time_i;
      from_q[in_channel_i]  <= in_from_i;
      to_q[in_channel_i]    <= in_to_i;
      dur_q[in_channel_i]   <= in_dur_i;
      loop_q[in_channel_i]  <= in_loop_i;
    end
    if (cmd_i.tick_latch) begin
      time_q <= in_time_i;
    end
    if (cmd_i.load) begin
      elapsed_q <= time_q - start_q[cmd_i.idx];
    end else if (cmd_i.mod_take) begin
      elapsed_q <= rem_q;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(mag) * PROD_W'(elapsed_q);
    end
    if (cmd_i.mod_start) begin
      rem_q <= '0;
      dvd_q <= elapsed_q;
    end else if (cmd_i.quo_start) begin
      rem_q <= prod_q[PROD_W-1:DATA_W];
      dvd_q <= prod_q[DATA_W-1:0];
    end else if (busy_q) begin
      rem_q <= rem_step;
      dvd_q <= {dvd_q[DATA_W-2:0], ge};
    end
    if (cmd_i.emit) begin
      out_ch_q   <= cmd_i.idx;
      out_val_q  <= fin ? to_cur : lerp_val;
      out_fin_q  <= fin;
      out_last_q <= ~|above;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_ch_q;
  assign out_value_o    = out_val_q;
  assign out_finished_o = out_fin_q;
  assign out_last_o     = out_last_q;

`ifndef SYNTH
  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && fin) |=> !active_q[$past(cmd_i.idx)])
    else $error("finished channel still active");
  a_start_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start_wr && ch_ok) |=> active_q[$past(in_channel_i)])
    else $error("started channel not active");
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit))
    else $error("output valid without an emit");
`endif

endmodule

// File: rtl/multichannel_linear_tween.sv
// multichannel_linear_tween: top level joining controller and datapath
// depends on mlt_pkg, mlt_if, mlt_ctrl, mlt_dp
//
// channel  dir  payload
// in_i     in   kind, channel, time_req, from_value, to_value, duration, loop
// out_o    out  channel_out, value, finished, last
//
// a start transaction is written from the idle state; a tick scans the channels,
// skipping inactive ones, loading, checking and emitting finishing ones, adding the
// multiply and 32-step quotient on the shared serial divider for interpolated ones,
// and first a 32-step modulo for a looping channel past a nonzero duration;
// no input is taken until the tick's last result sits in the output register
// a stalled output holds the scan at that channel; reset clears the active mask
module multichannel_linear_tween
  import mlt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mlt_in_if.sink    in_i,
  mlt_out_if.source out_o
);

  mlt_cmd_t cmd;
  mlt_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  mlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_channel_i   (in_i.channel),
    .in_time_i      (in_i.time_req),
    .in_from_i      (in_i.from_value),
    .in_to_i        (in_i.to_value),
    .in_dur_i       (in_i.duration),
    .in_loop_i      (in_i.loop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_channel_o  (out_o.channel_out),
    .out_value_o    (out_o.value),
    .out_finished_o (out_o.finished),
    .out_last_o     (out_o.last)
  );

endmodule

// File: sim/tb.sv
// tb: self-checking testbench for multichannel_linear_tween, a directed table
// then random start/tick traffic, checked against a built-in tween predictor
// depends on mlt_pkg, mlt_if and the multichannel_linear_tween rtl
`timescale 1ns / 1ps

module tb;
  import mlt_pkg::*;

  typedef struct packed {
    logic                     kind;
    logic [CHAN_W-1:0]        channel;
    logic [DATA_W-1:0]        time_req;
    logic signed [DATA_W-1:0] from_value;
    logic signed [DATA_W-1:0] to_value;
    logic [DATA_W-1:0]        duration;
    logic                     loop;
  } tween_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]        channel_out;
    logic signed [DATA_W-1:0] value;
    logic                     finished;
    logic                     last;
  } tween_result_t;

  typedef struct packed {
    tween_item_t   item;
    logic          pinned;
    tween_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mlt_in_if  in_if ();
  mlt_out_if out_if ();

  multichannel_linear_tween DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [CHANNELS-1:0] chan_active;
  logic [DATA_W-1:0]   chan_start [CHANNELS];
  logic [DATA_W-1:0]   chan_from  [CHANNELS];
  logic [DATA_W-1:0]   chan_to    [CHANNELS];
  logic [DATA_W-1:0]   chan_dur   [CHANNELS];
  logic                chan_loop  [CHANNELS];

  tween_result_t tick_results[$];
  tween_result_t expected_results[$];
  stim_row_t     directed_rows[$];
  int            mismatches = 0;
  bit            calm = 1'b0;

  function automatic void advance_tween(input tween_item_t it);
    logic [DATA_W-1:0]        elapsed;
    logic signed [DATA_W-1:0] from_s;
    logic signed [DATA_W-1:0] to_s;
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          mag;
    logic [PROD_W-1:0]        quo;
    tween_result_t            r;
    tick_results.delete();
    if (it.kind == KIND_START) begin
      if (int'(it.channel) < CHANNELS) begin
        chan_start[it.channel] = it.time_req;
        chan_from[it.channel]  = it.from_value;
        chan_to[it.channel]    = it.to_value;
        chan_dur[it.channel]   = it.duration;
        chan_loop[it.channel]  = it.loop;
        chan_active[it.channel] = 1'b1;
      end
      return;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      if (chan_active[i]) begin
        elapsed = it.time_req - chan_start[i];
        if (chan_loop[i] && chan_dur[i] != 0 && elapsed >= chan_dur[i])
          elapsed = elapsed % chan_dur[i];
        r.channel_out = CHAN_W'(i);
        r.last = 1'b0;
        if (elapsed < chan_dur[i]) begin
          from_s = chan_from[i];
          to_s   = chan_to[i];
          diff   = (DATA_W+1)'(to_s) - (DATA_W+1)'(from_s);
          mag    = diff[DATA_W] ? -diff : diff;
          quo    = (PROD_W'(mag) * PROD_W'(elapsed)) / PROD_W'(chan_dur[i]);
          r.value = diff[DATA_W] ? chan_from[i] - quo[DATA_W-1:0]
                                 : chan_from[i] + quo[DATA_W-1:0];
          r.finished = 1'b0;
        end else begin
          r.value = chan_to[i];
          r.finished = 1'b1;
          chan_active[i] = 1'b0;
        end
        tick_results.push_back(r);
      end
    end
    if (tick_results.size() != 0)
      tick_results[tick_results.size() - 1].last = 1'b1;
  endfunction

  function automatic tween_item_t start_item(input logic [CHAN_W-1:0] ch,
                                             input logic [DATA_W-1:0] t,
                                             input logic [DATA_W-1:0] from_v,
                                             input logic [DATA_W-1:0] to_v,
                                             input logic [DATA_W-1:0] dur,
                                             input logic lp);
    tween_item_t it;
    it.kind = KIND_START;
    it.channel = ch;
    it.time_req = t;
    it.from_value = from_v;
    it.to_value = to_v;
    it.duration = dur;
    it.loop = lp;
    return it;
  endfunction

  // unused fields of a tick carry noise
  function automatic tween_item_t tick_item(input logic [DATA_W-1:0] t);
    tween_item_t it;
    it.kind = KIND_TICK;
    it.channel = CHAN_W'($urandom);
    it.time_req = t;
    it.from_value = $urandom;
    it.to_value = $urandom;
    it.duration = $urandom;
    it.loop = 1'($urandom);
    return it;
  endfunction

  function automatic tween_result_t result_of(input logic [CHAN_W-1:0] ch,
                                              input logic [DATA_W-1:0] v,
                                              input logic fin);
    tween_result_t r;
    r.channel_out = ch;
    r.value = v;
    r.finished = fin;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input tween_item_t it, input logic pinned,
                         input tween_result_t want);
    stim_row_t row;
    row.item = it;
    row.pinned = pinned;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // valid is left high after a transaction; the next call lowers it only to idle
  task automatic drive_item(input tween_item_t it, input logic pinned,
                            input tween_result_t want);
    while (!calm && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= it.kind;
    in_if.channel    <= it.channel;
    in_if.time_req   <= it.time_req;
    in_if.from_value <= it.from_value;
    in_if.to_value   <= it.to_value;
    in_if.duration   <= it.duration;
    in_if.loop       <= it.loop;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    advance_tween(it);
    if (pinned) begin
      expected_results.push_back(want);
    end else begin
      foreach (tick_results[k]) expected_results.push_back(tick_results[k]);
    end
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    tween_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: channel_out %0d value %h",
               out_if.channel_out, out_if.value);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.channel_out !== want.channel_out) begin
          $error("channel_out: expected %0d, got %0d", want.channel_out,
                 out_if.channel_out);
          mismatches++;
        end
        if (out_if.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, out_if.value);
          mismatches++;
        end
        if (out_if.finished !== want.finished) begin
          $error("finished: expected %b, got %b", want.finished, out_if.finished);
          mismatches++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_if.last);
          mismatches++;
        end
      end
    end
    out_if.ready <= calm || ($urandom_range(99) >= 13);
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] tween_time;
    logic [DATA_W-1:0] dur;
    logic [DATA_W-1:0] st;
    int                spin;
    tween_result_t     none;
    none = '0;
    chan_active = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_START;
    in_if.channel = '0;
    in_if.time_req = '0;
    in_if.from_value = '0;
    in_if.to_value = '0;
    in_if.duration = '0;
    in_if.loop = 1'b0;
    out_if.ready = 1'b0;

    // tick with nothing active
    add_row(tick_item(32'd0), 1'b0, none);
    // zero duration with loop set still finishes at once
    add_row(start_item(3'd0, 32'd100, 32'h0000_0000, 32'h0001_0000, 32'd0, 1'b1), 1'b0, none);
    add_row(tick_item(32'd100), 1'b1, result_of(3'd0, 32'h0001_0000, 1'b1));
    // full-scale swing, longest duration, elapsed time wrapping
    add_row(start_item(3'd7, 32'hffff_fff0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0),
            1'b0, none);
    add_row(tick_item(32'h0000_0010), 1'b0, none);
    add_row(tick_item(32'hffff_ffef), 1'b1, result_of(3'd7, 32'h7fff_ffff, 1'b1));
    // looping channel, downward swing, wraps back to from
    add_row(start_item(3'd3, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd10, 1'b1), 1'b0, none);
    add_row(tick_item(32'd25), 1'b0, none);
    add_row(tick_item(32'd30), 1'b1, result_of(3'd3, 32'h7fff_ffff, 1'b0));
    add_row(start_item(3'd5, 32'd50, 32'hffff_0000, 32'h0003_0000, 32'd4, 1'b0), 1'b0, none);
    add_row(start_item(3'd1, 32'd0, 32'h0, 32'h0, 32'd1, 1'b0), 1'b0, none);
    add_row(tick_item(32'd52), 1'b0, none);
    // restart of an active channel
    add_row(start_item(3'd5, 32'd60, 32'h0000_0100, 32'h0000_0200, 32'h100, 1'b0), 1'b0, none);
    add_row(tick_item(32'h80), 1'b0, none);
    // fill every channel
    add_row(start_item(3'd2, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1),
            1'b0, none);
    add_row(start_item(3'd4, 32'd0, 32'hffff_ffff, 32'h0000_0001, 32'd3, 1'b0), 1'b0, none);
    add_row(start_item(3'd6, 32'd1000, 32'h1234_5678, 32'h8765_4321, 32'd1000, 1'b1), 1'b0, none);
    add_row(start_item(3'd0, 32'd0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b0), 1'b0, none);
    add_row(start_item(3'd7, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd7, 1'b1), 1'b0, none);
    add_row(start_item(3'd1, 32'd5, 32'h8000_0000, 32'h8000_0000, 32'd9, 1'b1), 1'b0, none);
    add_row(start_item(3'd5, 32'd0, 32'h0001_0000, 32'hffff_0000, 32'd300, 1'b0), 1'b0, none);
    add_row(tick_item(32'h7fff_ffff), 1'b0, none);
    add_row(tick_item(32'hffff_ffff), 1'b0, none);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k])
      drive_item(directed_rows[k].item, directed_rows[k].pinned, directed_rows[k].want);
    hold_until_drained();

    tween_time = 32'd0;
    for (int n = 0; n < 410; n++) begin
      calm = (n >= 200 && n < 280);
      if (n % 100 == 99) hold_until_drained();
      if ($urandom_range(99) < 45) begin
        if ($urandom_range(19) == 0) tween_time = $urandom;
        else tween_time = tween_time + $urandom_range(0, 150);
        drive_item(tick_item(tween_time), 1'b0, none);
      end else begin
        case ($urandom_range(15))
          0: dur = '0;
          1: dur = $urandom;
          2: dur = '1;
          default: dur = $urandom_range(1, 400);
        endcase
        if ($urandom_range(9) == 0) st = $urandom;
        else st = tween_time - $urandom_range(0, 100);
        drive_item(start_item(CHAN_W'($urandom_range(CHANNELS - 1)), st, pick_word(),
                              pick_word(), dur, 1'($urandom)), 1'b0, none);
      end
    end
    calm = 1'b0;

    in_if.valid <= 1'b0;
    spin = 0;
    while (expected_results.size() != 0 && spin < 50000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (600) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected transactions never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
